/* hw/rtl/hisc_pkg.sv */
// Shared types and constants of the homography inlier scorer.
package hisc_pkg;

  localparam int NW      = 58;
  localparam int MW      = 57;
  localparam int QW      = 41;
  localparam int IDX_W   = 10;
  localparam int EPOCH_W = 8;
  localparam int SCORE_W = 48;
  localparam int CNT_W   = 13;

  localparam logic [NW-1:0] DEN_ONE = {{(NW-39){1'b0}}, 1'b1, 38'b0};
  localparam logic [QW-1:0] QUOT_CAP = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [2:0] {
    CFG_H_ROW0     = 3'd0,
    CFG_H_ROW1     = 3'd1,
    CFG_H_TRANS    = 3'd2,
    CFG_H_PERSP    = 3'd3,
    CFG_THRESHOLD  = 3'd4,
    CFG_USE_SCORES = 3'd5,
    CFG_USE_INDEX  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] h0;
    logic signed [31:0] h1;
    logic signed [31:0] h2;
    logic signed [31:0] h3;
    logic signed [31:0] h4;
    logic signed [31:0] h5;
    logic signed [31:0] h6;
    logic signed [31:0] h7;
    logic [31:0]        thr;
    logic               use_scores;
    logic               use_index;
  } cfg_t;

  typedef struct packed {
    logic               ok;
    logic [31:0]        err;
    logic signed [31:0] mscore;
    logic [IDX_W-1:0]   idx;
    logic               last;
  } item_t;

  typedef enum logic [3:0] {
    F_IDLE, F_MUL, F_SUM, F_MAG, F_CHK, F_DIV, F_RND, F_DIFF, F_SQ, F_ERR
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR, B_IDLE, B_EVAL
  } back_state_t;

endpackage

/* hw/rtl/hisc_ram.sv */
// Generic single-port-write, registered-read RAM.
module hisc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/hisc_front.sv */
// Front end: projection through the homography and squared reprojection error.
module hisc_front #(
  parameter int MODEL_POINTS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hisc_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [23:0]  in_src_x,
  input  logic signed [23:0]  in_src_y,
  input  logic signed [23:0]  in_dst_x,
  input  logic signed [23:0]  in_dst_y,
  input  logic signed [31:0]  in_match_score,
  input  logic [9:0]          in_model_index,
  input  logic                in_last_point,
  output logic                push_valid,
  output hisc_pkg::item_t     push_item,
  input  logic                push_ready
);

  localparam int NW = hisc_pkg::NW;
  localparam int MW = hisc_pkg::MW;
  localparam int QW = hisc_pkg::QW;

  function automatic logic [hisc_pkg::IDX_W-1:0] idx_mod(input logic [9:0] v);
    int r;
    r = int'(v);
    for (int k = 6; k >= 0; k--) begin
      if (r >= (MODEL_POINTS << k)) r = r - (MODEL_POINTS << k);
    end
    return hisc_pkg::IDX_W'(r);
  endfunction

  hisc_pkg::front_state_t state_r, state_nxt;

  logic signed [23:0] sx_r, sy_r, tx_r, ty_r;
  logic signed [31:0] ms_r;
  logic [9:0]         idx_in_r;
  logic [hisc_pkg::IDX_W-1:0] idx_r;
  logic               last_r;
  logic signed [55:0] p0_r, p1_r, p3_r, p4_r, p6_r, p7_r;
  logic signed [NW-1:0] nx_r, ny_r, den_r;
  logic [MW-1:0]      ax_r, ay_r, b_r, rx_r, ry_r;
  logic               negx_r, negy_r, zero_r, capx_r, capy_r;
  logic [QW-1:0]      dvx_r, dvy_r, qx_r, qy_r, px_r, py_r;
  logic [5:0]         it_r;
  logic signed [31:0] dx_r, dy_r;
  logic [61:0]        sqx_r, sqy_r;

  logic [MW:0]        tx_div, ty_div;
  logic               gex, gey;
  logic [QW:0]        qpx, qpy;
  logic [QW-1:0]      qrx, qry;
  logic signed [42:0] spx, spy, ddx, ddy;
  logic signed [63:0] mx, my;
  logic [62:0]        ssum;
  logic [54:0]        err;

  localparam logic signed [42:0] DCAP = 43'sd2147483647;

  always_comb begin
    tx_div = {rx_r, dvx_r[QW-1]};
    ty_div = {ry_r, dvy_r[QW-1]};
    gex    = tx_div >= {1'b0, b_r};
    gey    = ty_div >= {1'b0, b_r};
    qpx    = {1'b0, qx_r} + (QW+1)'(1);
    qpy    = {1'b0, qy_r} + (QW+1)'(1);
    qrx    = qpx[QW:1];
    qry    = qpy[QW:1];
    spx    = negx_r ? -$signed({2'b0, px_r}) : $signed({2'b0, px_r});
    spy    = negy_r ? -$signed({2'b0, py_r}) : $signed({2'b0, py_r});
    ddx    = spx - 43'(tx_r);
    ddy    = spy - 43'(ty_r);
    if (ddx > DCAP) ddx = DCAP;
    if (ddx < -DCAP) ddx = -DCAP;
    if (ddy > DCAP) ddy = DCAP;
    if (ddy < -DCAP) ddy = -DCAP;
    mx     = dx_r * dx_r;
    my     = dy_r * dy_r;
    ssum   = {1'b0, sqx_r} + {1'b0, sqy_r} + 63'd128;
    err    = ssum[62:8];
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = state_r != hisc_pkg::F_IDLE;
    push_valid = state_r == hisc_pkg::F_ERR;
    push_item.ok     = !zero_r && (err <= {23'b0, cfg.thr});
    push_item.err    = err[31:0];
    push_item.mscore = ms_r;
    push_item.idx    = idx_r;
    push_item.last   = last_r;
    unique case (state_r)
      hisc_pkg::F_IDLE: if (in_valid) state_nxt = hisc_pkg::F_MUL;
      hisc_pkg::F_MUL:  state_nxt = hisc_pkg::F_SUM;
      hisc_pkg::F_SUM:  state_nxt = hisc_pkg::F_MAG;
      hisc_pkg::F_MAG:  state_nxt = hisc_pkg::F_CHK;
      hisc_pkg::F_CHK:  state_nxt = hisc_pkg::F_DIV;
      hisc_pkg::F_DIV:  if (it_r == 6'(QW-1)) state_nxt = hisc_pkg::F_RND;
      hisc_pkg::F_RND:  state_nxt = hisc_pkg::F_DIFF;
      hisc_pkg::F_DIFF: state_nxt = hisc_pkg::F_SQ;
      hisc_pkg::F_SQ:   state_nxt = hisc_pkg::F_ERR;
      hisc_pkg::F_ERR:  if (push_ready) state_nxt = hisc_pkg::F_IDLE;
      default:          state_nxt = hisc_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hisc_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      hisc_pkg::F_IDLE: begin
        sx_r     <= in_src_x;
        sy_r     <= in_src_y;
        tx_r     <= in_dst_x;
        ty_r     <= in_dst_y;
        ms_r     <= in_match_score;
        idx_in_r <= in_model_index;
        last_r   <= in_last_point;
      end
      hisc_pkg::F_MUL: begin
        p0_r  <= $signed(cfg.h0) * sx_r;
        p1_r  <= $signed(cfg.h1) * sy_r;
        p3_r  <= $signed(cfg.h3) * sx_r;
        p4_r  <= $signed(cfg.h4) * sy_r;
        p6_r  <= $signed(cfg.h6) * sx_r;
        p7_r  <= $signed(cfg.h7) * sy_r;
        idx_r <= idx_mod(idx_in_r);
      end
      hisc_pkg::F_SUM: begin
        nx_r  <= NW'(p0_r) + NW'(p1_r) + (NW'($signed(cfg.h2)) <<< 16);
        ny_r  <= NW'(p3_r) + NW'(p4_r) + (NW'($signed(cfg.h5)) <<< 16);
        den_r <= NW'(p6_r) + NW'(p7_r) + $signed(hisc_pkg::DEN_ONE);
      end
      hisc_pkg::F_MAG: begin
        ax_r   <= MW'(nx_r[NW-1] ? -nx_r : nx_r);
        ay_r   <= MW'(ny_r[NW-1] ? -ny_r : ny_r);
        b_r    <= MW'(den_r[NW-1] ? -den_r : den_r);
        negx_r <= nx_r[NW-1] ^ den_r[NW-1];
        negy_r <= ny_r[NW-1] ^ den_r[NW-1];
        zero_r <= den_r == '0;
      end
      hisc_pkg::F_CHK: begin
        capx_r <= {26'b0, ax_r} >= {b_r, 26'b0};
        capy_r <= {26'b0, ay_r} >= {b_r, 26'b0};
        rx_r   <= ax_r >> 26;
        ry_r   <= ay_r >> 26;
        dvx_r  <= {ax_r[25:0], 15'b0};
        dvy_r  <= {ay_r[25:0], 15'b0};
        qx_r   <= '0;
        qy_r   <= '0;
        it_r   <= '0;
      end
      hisc_pkg::F_DIV: begin
        rx_r  <= gex ? MW'(tx_div - {1'b0, b_r}) : MW'(tx_div);
        ry_r  <= gey ? MW'(ty_div - {1'b0, b_r}) : MW'(ty_div);
        qx_r  <= {qx_r[QW-2:0], gex};
        qy_r  <= {qy_r[QW-2:0], gey};
        dvx_r <= dvx_r << 1;
        dvy_r <= dvy_r << 1;
        it_r  <= it_r + 6'd1;
      end
      hisc_pkg::F_RND: begin
        px_r <= (capx_r || qrx > hisc_pkg::QUOT_CAP) ? hisc_pkg::QUOT_CAP : qrx;
        py_r <= (capy_r || qry > hisc_pkg::QUOT_CAP) ? hisc_pkg::QUOT_CAP : qry;
      end
      hisc_pkg::F_DIFF: begin
        dx_r <= 32'(ddx);
        dy_r <= 32'(ddy);
      end
      hisc_pkg::F_SQ: begin
        sqx_r <= mx[61:0];
        sqy_r <= my[61:0];
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/hisc_queue.sv */
// Two-entry queue between front end and scoring back end.
module hisc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  hisc_pkg::item_t push_item,
  output logic            push_ready,
  input  logic            pop,
  output logic            head_valid,
  output hisc_pkg::item_t head_item
);

  hisc_pkg::item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push;

  assign push_ready = cnt_r != 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head_item  = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(pop);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("pop from empty queue");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !do_push) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("queue count lost a pop");

endmodule

/* hw/rtl/hisc_back.sv */
// Back end: used-index bitmap, inlier count and score accumulation.
module hisc_back #(
  parameter int MODEL_POINTS = 1024,
  parameter int MAX_POINTS   = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hisc_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  hisc_pkg::item_t    q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_inlier,
  output logic [12:0]        out_inlier_count,
  output logic signed [47:0] out_total_score,
  output logic               out_run_done
);

  localparam int IW = $clog2(MODEL_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = hisc_pkg::EPOCH_W;
  localparam int SW = hisc_pkg::SCORE_W;
  localparam logic signed [SW:0] SMAX = (SW+1)'((64'sd1 <<< (SW-1)) - 64'sd1);
  localparam logic signed [SW:0] SMIN = -(SW+1)'(64'sd1 <<< (SW-1));

  hisc_pkg::back_state_t state_r, state_nxt;
  hisc_pkg::item_t       cur_r, cur_nxt;
  logic [EW-1:0]         epoch_r, epoch_nxt;
  logic [IW-1:0]         clr_r, clr_nxt;
  logic signed [SW-1:0]  acc_r, acc_nxt, acc_upd;
  logic [CW-1:0]         cnt_r, cnt_nxt, cnt_upd;
  logic                  ov_r, ov_nxt;
  logic                  oinl_r;
  logic [12:0]           ocnt_r;
  logic signed [SW-1:0]  oscore_r;
  logic                  odone_r;

  logic                  we;
  logic [IW-1:0]         waddr, raddr;
  logic [EW-1:0]         wdata, rdata;

  logic                  out_free, fire, used, hit, do_add;
  logic signed [32:0]    addv;
  logic signed [SW:0]    sum;

  hisc_ram #(.WIDTH(EW), .DEPTH(MODEL_POINTS)) u_used (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    out_free = !ov_r || !out_stall;
    used     = cfg.use_index && (rdata == epoch_r);
    hit      = cur_r.ok && !used;
    do_add   = 1'b0;
    addv     = '0;
    if (hit) begin
      do_add = 1'b1;
      addv   = cfg.use_scores ? 33'(cur_r.mscore) : -$signed({1'b0, cur_r.err});
    end else if (!used && !cfg.use_scores) begin
      do_add = 1'b1;
      addv   = -$signed({1'b0, cfg.thr});
    end
    sum = (SW+1)'(acc_r) + (SW+1)'(addv);
    if (!do_add) acc_upd = acc_r;
    else if (sum > SMAX) acc_upd = SW'(SMAX);
    else if (sum < SMIN) acc_upd = SW'(SMIN);
    else acc_upd = SW'(sum);
    cnt_upd = (hit && cnt_r < CW'(MAX_POINTS)) ? cnt_r + CW'(1) : cnt_r;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    epoch_nxt = epoch_r;
    clr_nxt   = clr_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && out_stall;
    q_pop     = 1'b0;
    fire      = 1'b0;
    we        = 1'b0;
    waddr     = IW'(cur_r.idx);
    wdata     = epoch_r;
    raddr     = IW'(cur_r.idx);
    unique case (state_r)
      hisc_pkg::B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(MODEL_POINTS - 1)) state_nxt = hisc_pkg::B_IDLE;
      end
      hisc_pkg::B_IDLE: begin
        raddr = IW'(q_item.idx);
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = hisc_pkg::B_EVAL;
        end
      end
      hisc_pkg::B_EVAL: begin
        if (out_free) begin
          fire      = 1'b1;
          ov_nxt    = 1'b1;
          we        = hit && cfg.use_index;
          state_nxt = hisc_pkg::B_IDLE;
          acc_nxt   = acc_upd;
          cnt_nxt   = cnt_upd;
          if (cur_r.last) begin
            acc_nxt = '0;
            cnt_nxt = '0;
            if (epoch_r == {EW{1'b1}}) begin
              epoch_nxt = EW'(1);
              clr_nxt   = '0;
              state_nxt = hisc_pkg::B_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EW'(1);
            end
          end
        end
      end
      default: state_nxt = hisc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hisc_pkg::B_CLEAR;
      epoch_r <= EW'(1);
      clr_r   <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      epoch_r <= epoch_nxt;
      clr_r   <= clr_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (fire) begin
      oinl_r   <= hit;
      ocnt_r   <= 13'(cnt_upd);
      oscore_r <= acc_upd;
      odone_r  <= cur_r.last;
    end
  end

  assign out_valid        = ov_r;
  assign out_is_inlier    = oinl_r;
  assign out_inlier_count = ocnt_r;
  assign out_total_score  = oscore_r;
  assign out_run_done     = odone_r;

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(MAX_POINTS))
    else $error("inlier count above limit");
  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cur_r.last) |=> (acc_r == '0 && cnt_r == '0))
    else $error("run state not cleared");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hisc_pkg::B_CLEAR |-> !q_pop)
    else $error("item taken during bitmap clear");

endmodule

/* hw/rtl/homography_inlier_scorer_core.sv */
// Top level of the homography inlier scorer: configuration registers and block wiring.
//
// Usage: program the homography, threshold and mode bits through the cfg_ port
// (cfg_ready is always high; a write to index 7 is ignored) while the block is idle.
// Feed one correspondence per transfer on the in_ channel; each gives exactly one
// result transfer on the out_ channel with the inlier flag, running inlier count and
// running score. The transfer with in_last_point set closes the run: its result shows
// the final totals and carries out_run_done, and count, score and used-index marks clear.
// The front end takes one correspondence at a time, paced by the 41-step restoring
// divider of the projection, and holds in_stall high while an item is in flight.
// A two-entry queue parts the projection front end from the scoring back end, and the
// result sits in an output register, so a stalled receiver holds the result steady
// while the next item is still projected.
// Reset clears the configuration and control registers and starts a pass that
// clears the used-index memory; the same pass runs again after every 255th run.
module homography_inlier_scorer_core #(
  parameter int MODEL_POINTS = 1024,
  parameter int MAX_POINTS   = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_src_x,
  input  logic signed [23:0] in_src_y,
  input  logic signed [23:0] in_dst_x,
  input  logic signed [23:0] in_dst_y,
  input  logic signed [31:0] in_match_score,
  input  logic [9:0]         in_model_index,
  input  logic               in_last_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_inlier,
  output logic [12:0]        out_inlier_count,
  output logic signed [47:0] out_total_score,
  output logic               out_run_done
);

  hisc_pkg::cfg_t  cfg_r;
  logic            push_valid, push_ready, q_valid, q_pop;
  hisc_pkg::item_t push_item, q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hisc_pkg::CFG_H_ROW0: begin
          cfg_r.h0 <= cfg_data[63:32];
          cfg_r.h1 <= cfg_data[31:0];
        end
        hisc_pkg::CFG_H_ROW1: begin
          cfg_r.h3 <= cfg_data[63:32];
          cfg_r.h4 <= cfg_data[31:0];
        end
        hisc_pkg::CFG_H_TRANS: begin
          cfg_r.h2 <= cfg_data[63:32];
          cfg_r.h5 <= cfg_data[31:0];
        end
        hisc_pkg::CFG_H_PERSP: begin
          cfg_r.h6 <= cfg_data[63:32];
          cfg_r.h7 <= cfg_data[31:0];
        end
        hisc_pkg::CFG_THRESHOLD:  cfg_r.thr        <= cfg_data[31:0];
        hisc_pkg::CFG_USE_SCORES: cfg_r.use_scores <= cfg_data[0];
        hisc_pkg::CFG_USE_INDEX:  cfg_r.use_index  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  hisc_front #(.MODEL_POINTS(MODEL_POINTS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_src_x       (in_src_x),
    .in_src_y       (in_src_y),
    .in_dst_x       (in_dst_x),
    .in_dst_y       (in_dst_y),
    .in_match_score (in_match_score),
    .in_model_index (in_model_index),
    .in_last_point  (in_last_point),
    .push_valid     (push_valid),
    .push_item      (push_item),
    .push_ready     (push_ready)
  );

  hisc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  hisc_back #(.MODEL_POINTS(MODEL_POINTS), .MAX_POINTS(MAX_POINTS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_inlier    (out_is_inlier),
    .out_inlier_count (out_inlier_count),
    .out_total_score  (out_total_score),
    .out_run_done     (out_run_done)
  );

endmodule
